// ----- src/fpfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-point format converter package
// Operation codes and the result record that is shared between files.
// ----------------------------------------------------------------------------
package fpfc_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_INT2FIX = 2'd0;
  localparam op_t OP_FLT2FIX = 2'd1;
  localparam op_t OP_FIX2FLT = 2'd2;
  localparam op_t OP_FIX2INT = 2'd3;

  typedef struct packed {
    logic [31:0] result;
    logic        saturated;
  } res_t;

endpackage

// ----- src/fixed_point_format_converter.sv -----
// ----------------------------------------------------------------------------
// Fixed-point format converter
// Converts between 32-bit fixed point, integers and IEEE single precision.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register while it is converted,
// and its result is captured in the output register, which drives out_valid.
// Throughput: one request per cycle; input register, conversion logic and
// output register form a two-stage pipeline that stalls only on out_ready.
// Reset: rst_n, synchronous, clears both stage valid flags.
module fixed_point_format_converter #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic        out_saturated
);

  logic          s1_vld_r;
  logic [1:0]    s1_op_r;
  logic [31:0]   s1_opd_r;
  logic          s2_vld_r;
  fpfc_pkg::res_t s2_res_r;
  fpfc_pkg::res_t core_res;
  logic          s2_adv;
  logic          s1_adv;

  assign s2_adv   = !s2_vld_r || out_ready;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  fpfc_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .op(s1_op_r), .operand(s1_opd_r), .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_op_r  <= in_op;
      s1_opd_r <= in_operand;
    end
    if (s2_adv && s1_vld_r) s2_res_r <= core_res;
  end

  assign out_valid     = s2_vld_r;
  assign out_result    = s2_res_r.result;
  assign out_saturated = s2_res_r.saturated;

  // A stalled result must not be overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // Only float-to-fixed conversions may saturate.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_op_r != fpfc_pkg::OP_FLT2FIX |-> !core_res.saturated)
    else $error("saturation outside float conversion");

  // A request in stage one moves on whenever stage two can take it.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_adv |=> s2_vld_r)
    else $error("request lost between stages");

endmodule

// ----- src/fpfc_core.sv -----
// ----------------------------------------------------------------------------
// Fixed-point format converter datapath
// Combinational conversion of one registered request into one result.
// ----------------------------------------------------------------------------
module fpfc_core #(
  parameter int FRAC_BITS = 8
) (
  input  fpfc_pkg::op_t op,
  input  logic [31:0]   operand,
  output fpfc_pkg::res_t res
);

  localparam int FB = FRAC_BITS;

  // Float to fixed
  logic        f_neg;
  logic [7:0]  f_ex;
  logic [22:0] f_fr;
  logic [23:0] f_m;
  logic [8:0]  f_exu;
  logic signed [10:0] f_s;
  logic [5:0]  f_sh;
  logic [63:0] f_mag;
  logic [63:0] f_rnd;
  logic [31:0] f_res;
  logic        f_sat;

  always_comb begin
    f_neg = operand[31];
    f_ex  = operand[30:23];
    f_fr  = operand[22:0];
    f_exu = (f_ex == 8'd0) ? 9'd1 : {1'b0, f_ex};
    f_m   = (f_ex == 8'd0) ? {1'b0, f_fr} : {1'b1, f_fr};
    f_s   = $signed({2'b00, f_exu}) - 11'sd150 + 11'(FB);
    f_sh  = '0;
    f_rnd = '0;
    if (f_s >= 0) begin
      if (f_s >= 11'sd40) f_mag = 64'd1 << 40;
      else f_mag = {40'd0, f_m} << f_s[5:0];
    end else begin
      if (-f_s > 11'sd25) f_mag = '0;
      else begin
        f_sh  = 6'(-f_s);
        f_rnd = {40'd0, f_m} + (64'd1 << (f_sh - 6'd1));
        f_mag = f_rnd >> f_sh;
      end
    end
    f_sat = 1'b0;
    if (f_ex == 8'hFF) begin
      f_sat = 1'b1;
      if (f_fr != '0) f_res = '0;
      else f_res = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (f_m == '0) begin
      f_res = '0;
    end else if (!f_neg) begin
      if (f_mag > 64'h7FFF_FFFF) begin
        f_sat = 1'b1;
        f_res = 32'h7FFF_FFFF;
      end else f_res = f_mag[31:0];
    end else begin
      if (f_mag > 64'h8000_0000) begin
        f_sat = 1'b1;
        f_res = 32'h8000_0000;
      end else f_res = 32'd0 - f_mag[31:0];
    end
  end

  // Fixed to float and fixed to int share the magnitude.
  logic [31:0] x_mag;
  logic [4:0]  x_p;
  logic [4:0]  x_sh;
  logic [31:0] x_rem;
  logic [31:0] x_half;
  logic [31:0] x_q;
  logic [7:0]  x_exp;
  logic [31:0] t_res;
  logic [31:0] i_q;

  always_comb begin
    x_mag = operand[31] ? 32'd0 - operand : operand;
    x_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_mag[i]) x_p = 5'(i);
    end
    x_sh = '0;
    x_rem = '0;
    x_half = '0;
    if (x_p <= 5'd23) begin
      x_q = x_mag << (5'd23 - x_p);
      x_exp = 8'({3'd0, x_p} + 8'd127 - 8'(FB));
    end else begin
      x_sh   = x_p - 5'd23;
      x_rem  = x_mag & ((32'd1 << x_sh) - 32'd1);
      x_half = 32'd1 << (x_sh - 5'd1);
      x_q    = x_mag >> x_sh;
      if (x_rem > x_half || (x_rem == x_half && x_q[0])) x_q = x_q + 32'd1;
      if (x_q[24]) begin
        x_q = x_q >> 1;
        x_exp = 8'({3'd0, x_p} + 8'd128 - 8'(FB));
      end else begin
        x_exp = 8'({3'd0, x_p} + 8'd127 - 8'(FB));
      end
    end
    t_res = (x_mag == '0) ? 32'd0 : {operand[31], x_exp, x_q[22:0]};
    i_q = x_mag >> FB;
  end

  always_comb begin
    res.saturated = 1'b0;
    case (op)
      fpfc_pkg::OP_INT2FIX: res.result = operand << FB;
      fpfc_pkg::OP_FLT2FIX: begin
        res.result = f_res;
        res.saturated = f_sat;
      end
      fpfc_pkg::OP_FIX2FLT: res.result = t_res;
      default: res.result = operand[31] ? 32'd0 - i_q : i_q;
    endcase
  end

endmodule
